[src/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clk edge outside reset.
`define FUFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clk edge, reset included.
`define FUFS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FUFS_ASSERT(lbl, prop, msg)
`define FUFS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[src/fufs_pkg.sv]
// ============================================================================
// fufs_pkg
// Types, codes and frame helpers of the flash update frame sequencer.
// ============================================================================
package fufs_pkg;

  localparam int LENGTH_WIDTH_DEF = 24;
  localparam int IMG_LEN_W        = 24;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_INDEX_W      = 3;
  localparam int FRAME_MAX        = 10;

  // request opcodes
  localparam logic [2:0] OP_START_AUTO  = 3'd0;
  localparam logic [2:0] OP_START_PLAIN = 3'd1;
  localparam logic [2:0] OP_SEND_OK     = 3'd2;
  localparam logic [2:0] OP_SEND_FAIL   = 3'd3;
  localparam logic [2:0] OP_ABORT       = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_FINISHED = 2'd1;
  localparam logic [1:0] STATUS_LINK     = 2'd2;
  localparam logic [1:0] STATUS_ABORTED  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHIP_SELECT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ERASE_ADDR    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAGE_SIZE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAGE_COUNT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROG_ADDR     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_LENGTH  = 3'd5;

  // sequence steps
  localparam logic [3:0] STEP_SELECT     = 4'd0;
  localparam logic [3:0] STEP_UNLOCK     = 4'd1;
  localparam logic [3:0] STEP_ERASE_ADDR = 4'd2;
  localparam logic [3:0] STEP_PAGE_SIZE  = 4'd3;
  localparam logic [3:0] STEP_PAGE_COUNT = 4'd4;
  localparam logic [3:0] STEP_MASS_ERASE = 4'd5;
  localparam logic [3:0] STEP_PROG_ADDR  = 4'd6;
  localparam logic [3:0] STEP_DATA       = 4'd7;
  localparam logic [3:0] STEP_RETURN     = 4'd8;

  // frame bytes
  localparam logic [7:0] SYNC0    = 8'h55;
  localparam logic [7:0] SYNC1    = 8'haa;
  localparam logic [7:0] PAD_BYTE = 8'hff;

  localparam logic [7:0] CMD_SELECT  = 8'h00;
  localparam logic [7:0] CMD_PROTECT = 8'h01;
  localparam logic [7:0] CMD_ERASE   = 8'h02;
  localparam logic [7:0] CMD_PROGRAM = 8'h03;
  localparam logic [7:0] CMD_RETURN  = 8'h05;

  localparam logic [7:0] SUB_0 = 8'h00;
  localparam logic [7:0] SUB_1 = 8'h01;
  localparam logic [7:0] SUB_2 = 8'h02;
  localparam logic [7:0] SUB_3 = 8'h03;

  localparam logic [2:0] PLEN_NONE = 3'd0;
  localparam logic [2:0] PLEN_BYTE = 3'd1;
  localparam logic [2:0] PLEN_WORD = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] image_word;
  } in_req_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [1:0]  status_code;
  } out_req_t;

  typedef struct packed {
    logic [7:0]           chip_select;
    logic [31:0]          erase_start_address;
    logic [31:0]          erase_page_size;
    logic [31:0]          erase_page_count;
    logic [31:0]          program_start_address;
    logic [IMG_LEN_W-1:0] image_length;
  } cfg_t;

  // one staged frame (or a one-entry status report); byte 0 goes out first
  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      is_status;
    logic [1:0]                code;
  } frame_t;

  // 55 AA len cmd sub payload chk; payload taken MSB first from pay
  function automatic frame_t build_frame(input logic [7:0]  cmd,
                                         input logic [7:0]  sub,
                                         input logic [31:0] pay,
                                         input logic [2:0]  plen);
    frame_t     f;
    logic [7:0] len;
    logic [7:0] sum;
    f        = '0;
    len      = 8'(plen) + 8'd3;
    f.bytes[0] = SYNC0;
    f.bytes[1] = SYNC1;
    f.bytes[2] = len;
    f.bytes[3] = cmd;
    f.bytes[4] = sub;
    sum      = len + cmd + sub;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < plen) begin
        f.bytes[5 + i] = pay[31 - 8 * i -: 8];
        sum            = sum + pay[31 - 8 * i -: 8];
      end
    end
    f.bytes[4'd5 + 4'(plen)] = 8'd0 - sum;
    f.count     = 4'd6 + 4'(plen);
    f.is_status = 1'b0;
    f.code      = STATUS_NONE;
    return f;
  endfunction

  function automatic frame_t status_frame(input logic [1:0] code);
    frame_t f;
    f           = '0;
    f.count     = 4'd1;
    f.is_status = 1'b1;
    f.code      = code;
    return f;
  endfunction

endpackage

[src/fufs_ctrl.sv]
// ============================================================================
// fufs_ctrl
// Update sequencer state and single-pass frame builder for one request.
// ============================================================================
module fufs_ctrl #(
  parameter int LENGTH_WIDTH = fufs_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fufs_pkg::cfg_t      cfg,
  input  logic                req_fire,
  input  fufs_pkg::in_req_t   req,
  output logic                frame_emit,
  output fufs_pkg::frame_t    frame
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PLAIN = 2'd1,
    MODE_AUTO  = 2'd2
  } mode_t;

  localparam int LEN_EXT_W = 32;

  mode_t                   mode_r, mode_nxt;
  logic [3:0]              step_r, step_nxt;
  logic [LENGTH_WIDTH-1:0] left_r, left_nxt;
  logic                    ack_r, ack_nxt;

  logic [LEN_EXT_W-1:0]    len_ext;
  logic [LENGTH_WIDTH-1:0] len_load;

  // dispatch results
  mode_t                   mode_a;
  logic [3:0]              step_a;
  logic [LENGTH_WIDTH-1:0] left_a;
  logic                    run_emit;
  logic                    st_emit;
  logic [1:0]              st_code;

  // step emission results
  fufs_pkg::frame_t        e_frame;
  logic                    e_done;
  logic [3:0]              e_step;
  logic [LENGTH_WIDTH-1:0] e_left;
  logic                    ge4;
  logic [31:0]             data_word;

  assign len_ext  = LEN_EXT_W'(cfg.image_length);
  assign len_load = len_ext[LENGTH_WIDTH-1:0];

  // decode the request against the current state
  always_comb begin
    mode_a   = mode_r;
    step_a   = step_r;
    left_a   = left_r;
    run_emit = 1'b0;
    st_emit  = 1'b0;
    st_code  = fufs_pkg::STATUS_NONE;
    if (req_fire) begin
      case (req.opcode)
        fufs_pkg::OP_START_AUTO: begin
          mode_a   = MODE_AUTO;
          step_a   = fufs_pkg::STEP_SELECT;
          left_a   = len_load;
          run_emit = 1'b1;
        end
        fufs_pkg::OP_START_PLAIN: begin
          mode_a   = MODE_PLAIN;
          step_a   = fufs_pkg::STEP_DATA;
          left_a   = len_load;
          run_emit = 1'b1;
        end
        fufs_pkg::OP_SEND_OK: begin
          if (mode_r != MODE_IDLE && ack_r) begin
            if (mode_r == MODE_AUTO && step_r == fufs_pkg::STEP_RETURN) begin
              st_emit = 1'b1;
              st_code = fufs_pkg::STATUS_FINISHED;
            end else begin
              if (mode_r == MODE_AUTO && step_r < fufs_pkg::STEP_DATA) begin
                step_a = step_r + 4'd1;
              end
              run_emit = 1'b1;
            end
          end
        end
        fufs_pkg::OP_SEND_FAIL: begin
          if (mode_r != MODE_IDLE) begin
            st_emit = 1'b1;
            st_code = fufs_pkg::STATUS_LINK;
          end
        end
        fufs_pkg::OP_ABORT: begin
          if (mode_r != MODE_IDLE) begin
            st_emit = 1'b1;
            st_code = fufs_pkg::STATUS_ABORTED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // data frame payload: min(4, bytes left) image bytes, rest padded
  assign ge4 = (left_a >= LENGTH_WIDTH'(4));

  always_comb begin
    data_word = req.image_word;
    for (int i = 0; i < 4; i++) begin
      if (!ge4 && (LENGTH_WIDTH'(i) >= left_a)) begin
        data_word[31 - 8 * i -: 8] = fufs_pkg::PAD_BYTE;
      end
    end
  end

  // frame for the step reached
  always_comb begin
    e_frame = fufs_pkg::status_frame(fufs_pkg::STATUS_FINISHED);
    e_done  = 1'b0;
    e_step  = step_a;
    e_left  = left_a;
    case (step_a)
      fufs_pkg::STEP_SELECT:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_SELECT, fufs_pkg::SUB_1,
                                        {cfg.chip_select, 24'd0}, fufs_pkg::PLEN_BYTE);
      fufs_pkg::STEP_UNLOCK:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_PROTECT, fufs_pkg::SUB_0,
                                        32'd0, fufs_pkg::PLEN_NONE);
      fufs_pkg::STEP_ERASE_ADDR:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_ERASE, fufs_pkg::SUB_0,
                                        cfg.erase_start_address, fufs_pkg::PLEN_WORD);
      fufs_pkg::STEP_PAGE_SIZE:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_ERASE, fufs_pkg::SUB_1,
                                        cfg.erase_page_size, fufs_pkg::PLEN_WORD);
      fufs_pkg::STEP_PAGE_COUNT:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_ERASE, fufs_pkg::SUB_2,
                                        cfg.erase_page_count, fufs_pkg::PLEN_WORD);
      fufs_pkg::STEP_MASS_ERASE:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_ERASE, fufs_pkg::SUB_3,
                                        32'd0, fufs_pkg::PLEN_NONE);
      fufs_pkg::STEP_PROG_ADDR:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_PROGRAM, fufs_pkg::SUB_0,
                                        cfg.program_start_address, fufs_pkg::PLEN_WORD);
      fufs_pkg::STEP_DATA: begin
        if (left_a != '0) begin
          e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_PROGRAM, fufs_pkg::SUB_3,
                                          data_word, fufs_pkg::PLEN_WORD);
          e_left  = ge4 ? (left_a - LENGTH_WIDTH'(4)) : '0;
        end else if (mode_a == MODE_AUTO) begin
          e_step  = fufs_pkg::STEP_RETURN;
          e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_RETURN, fufs_pkg::SUB_0,
                                          32'd0, fufs_pkg::PLEN_NONE);
        end else begin
          e_done = 1'b1;
        end
      end
      fufs_pkg::STEP_RETURN:
        e_frame = fufs_pkg::build_frame(fufs_pkg::CMD_RETURN, fufs_pkg::SUB_0,
                                        32'd0, fufs_pkg::PLEN_NONE);
      default: e_done = 1'b1;
    endcase
  end

  // merge into next state and the staged frame
  always_comb begin
    mode_nxt   = mode_r;
    step_nxt   = step_r;
    left_nxt   = left_r;
    ack_nxt    = ack_r;
    frame_emit = st_emit | run_emit;
    frame      = fufs_pkg::status_frame(st_code);
    if (st_emit || (run_emit && e_done)) begin
      mode_nxt = MODE_IDLE;
      step_nxt = fufs_pkg::STEP_SELECT;
      left_nxt = '0;
      ack_nxt  = 1'b0;
      if (!st_emit) begin
        frame = e_frame;
      end
    end else if (run_emit) begin
      mode_nxt = mode_a;
      step_nxt = e_step;
      left_nxt = e_left;
      ack_nxt  = 1'b1;
      frame    = e_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      step_r <= fufs_pkg::STEP_SELECT;
      left_r <= '0;
      ack_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      step_r <= step_nxt;
      left_r <= left_nxt;
      ack_r  <= ack_nxt;
    end
  end

`include "assert_macros.svh"

  `FUFS_ASSERT(a_idle_no_ack, (mode_r == MODE_IDLE) |-> (!ack_r && left_r == '0), "idle dirty")
  `FUFS_ASSERT(a_plain_data, (mode_r == MODE_PLAIN) |-> (step_r == fufs_pkg::STEP_DATA), "plain")
  `FUFS_ASSERT(a_status_idles, (frame_emit && frame.is_status) |=> (mode_r == MODE_IDLE), "busy")

endmodule

[src/fufs_serializer.sv]
// ============================================================================
// fufs_serializer
// Holds one staged frame and shifts it out one byte per output request.
// ============================================================================
module fufs_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                frame_load,
  input  fufs_pkg::frame_t    frame_in,
  output logic                frame_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output fufs_pkg::out_req_t  out_data
);

  fufs_pkg::frame_t   fr_r, fr_nxt;
  logic               fr_valid_r, fr_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  fufs_pkg::out_req_t out_data_r, out_data_nxt;
  logic               out_load;
  logic               last;

  assign out_load    = fr_valid_r && (!out_valid_r || !out_stall);
  assign last        = (fr_r.count == 4'd1);
  // a new frame may enter once the current one hands over its final byte
  assign frame_ready = !fr_valid_r || (out_load && last);

  always_comb begin
    fr_r_default: begin
      fr_nxt       = fr_r;
      fr_valid_nxt = fr_valid_r;
    end
    if (frame_load) begin
      fr_nxt       = frame_in;
      fr_valid_nxt = 1'b1;
    end else if (out_load) begin
      fr_nxt.bytes = {8'h00, fr_r.bytes[fufs_pkg::FRAME_MAX-1:1]};
      fr_nxt.count = fr_r.count - 4'd1;
      if (last) begin
        fr_valid_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.item_kind   = fr_r.is_status;
      out_data_nxt.frame_byte  = fr_r.is_status ? 8'h00 : fr_r.bytes[0];
      out_data_nxt.frame_end   = last;
      out_data_nxt.status_code = fr_r.code;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fr_valid_r  <= fr_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fr_r       <= fr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "assert_macros.svh"

  `FUFS_ASSERT_RST(a_reset_empty, (!rst_n) |=> (!fr_valid_r && !out_valid_r), "stage not empty after reset")
  `FUFS_ASSERT(a_count_live, fr_valid_r |-> (fr_r.count != 4'd0), "staged frame with no bytes left")
  `FUFS_ASSERT(a_load_only_ready, frame_load |-> frame_ready, "frame loaded over a busy stage")
  `FUFS_ASSERT(a_status_single, (fr_valid_r && fr_r.is_status) |-> (fr_r.count == 4'd1), "status report longer than one entry")

endmodule

[src/flash_update_frame_sequencer_top.sv]
// ============================================================================
// flash_update_frame_sequencer_top
// Host-side frame sequencer for a serial bootloader flash update.
// ============================================================================
// Each request on the input channel (start auto, start plain, send ok, send
// failed, abort) is decoded in one pass against the sequencer state and turns
// into at most one staged frame: 55 AA len cmd sub payload checksum, six to
// ten bytes, or a single status report. The frame stage then emits one byte
// per output request, so a request that makes an n-byte frame occupies the
// block until its n bytes have moved into the output register; a byte is
// held back from that register only while the output register is valid and
// stalled. The next request is taken in the cycle the last byte of the
// current frame moves into the output register, so frames go out back to
// back with no gap. Configuration registers are written through cfg_we /
// cfg_index / cfg_wdata and must only change while the block is idle;
// indexes past the image length register are ignored.
module flash_update_frame_sequencer_top #(
  parameter int LENGTH_WIDTH = fufs_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  fufs_pkg::in_req_t                     in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output fufs_pkg::out_req_t                    out_data,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [fufs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fufs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  fufs_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             frame_ready;
  logic             req_fire;
  logic             frame_emit;
  fufs_pkg::frame_t frame;

  // configuration register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fufs_pkg::REG_CHIP_SELECT:  cfg_nxt.chip_select           = cfg_wdata[7:0];
        fufs_pkg::REG_ERASE_ADDR:   cfg_nxt.erase_start_address   = cfg_wdata;
        fufs_pkg::REG_PAGE_SIZE:    cfg_nxt.erase_page_size       = cfg_wdata;
        fufs_pkg::REG_PAGE_COUNT:   cfg_nxt.erase_page_count      = cfg_wdata;
        fufs_pkg::REG_PROG_ADDR:    cfg_nxt.program_start_address = cfg_wdata;
        fufs_pkg::REG_IMAGE_LENGTH:
          cfg_nxt.image_length = cfg_wdata[fufs_pkg::IMG_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a request is taken whenever the frame stage can accept its result
  assign in_stall = !frame_ready;
  assign req_fire = in_valid && frame_ready;

  fufs_ctrl #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .req_fire   (req_fire),
    .req        (in_data),
    .frame_emit (frame_emit),
    .frame      (frame)
  );

  fufs_serializer u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_load  (req_fire && frame_emit),
    .frame_in    (frame),
    .frame_ready (frame_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
